FILE: hdl/segment_table_overlap_check_top_assert.svh
// Assertion macros for the segment table overlap check block.
`ifndef SEGMENT_TABLE_OVERLAP_CHECK_TOP_ASSERT_SVH
`define SEGMENT_TABLE_OVERLAP_CHECK_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define STOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define STOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stoc_pkg.sv
// Types and codes shared by the segment table overlap check modules.
package stoc_pkg;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [2:0] ST_CLEARED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_OVERLAP  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_MISSING  = 3'd5;

  typedef struct packed {
    logic        valid;
    logic [1:0]  action;
    logic [15:0] nb;
    logic [16:0] ne;
    logic [3:0]  num;
    logic        hit;
    logic        found;
    logic [15:0] fbase;
    logic [15:0] flimit;
    logic [63:0] fname;
  } tok_t;

  typedef struct packed {
    logic        en;
    logic [15:0] base;
    logic [15:0] limit;
    logic [63:0] name;
  } wr_t;

endpackage

FILE: hdl/stoc_cell.sv
// One table cell: holds a segment entry and checks the passing query beat.
module stoc_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic [CW-1:0]  count,
  input  stoc_pkg::wr_t  wr,
  input  stoc_pkg::tok_t tok_in,
  output stoc_pkg::tok_t tok_out
);
  import stoc_pkg::*;

  localparam int NW = (CW > 4) ? CW : 4;

  logic [15:0] base;
  logic [15:0] limit;
  logic [63:0] name;
  logic [16:0] se;
  logic        active;
  logic        meet;
  logic        pick;
  tok_t        tok_next;

  always_ff @(posedge clk) begin
    if (wr.en && (count == CW'(IDX))) begin
      base  <= wr.base;
      limit <= wr.limit;
      name  <= wr.name;
    end
  end

  always_comb begin
    se       = {1'b0, base} + {1'b0, limit};
    active   = CW'(IDX) < count;
    meet     = ({1'b0, tok_in.nb} < se) && ({1'b0, base} < tok_in.ne);
    pick     = tok_in.valid && (tok_in.action == ACT_LOOKUP) && active &&
               (NW'(tok_in.num) == NW'(IDX));
    tok_next = tok_in;
    if (tok_in.valid && (tok_in.action == ACT_INSERT) && active && meet) begin
      tok_next.hit = 1'b1;
    end
    if (pick) begin
      tok_next.found  = 1'b1;
      tok_next.fbase  = base;
      tok_next.flimit = limit;
      tok_next.fname  = name;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

FILE: hdl/segment_table_overlap_check_top.sv
// Segment table with overlap check: top level with the row of table cells.
//
// Each accepted beat walks once along a row of MAX_SEGMENTS cells, one cell
// per cycle unless a stalled result holds the row, and its result is
// registered when it leaves the last cell; the next beat is accepted only
// after that result is registered, so the row holds one beat. Cell j
// holds table entry j, checks an insert against its own span and hands out
// its entry on a lookup of number j; the insert is written to the free cell
// as the beat leaves the row. A beat with action 3 is taken and dropped
// without a result. Entries hold whatever was last written; clear only
// resets the entry count.
module segment_table_overlap_check_top #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // seg_base_in[15:0], seg_limit_in[31:16], seg_name_in[95:32],
  // seg_number_in[99:96], zero pad
  input  logic [103:0] s_tdata,
  // action[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // seg_number_out[3:0], seg_base_out[19:4], seg_limit_out[35:20],
  // seg_name_out[99:36], zero pad
  output logic [103:0] m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser
);
  import stoc_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  tok_t          chain [MAX_SEGMENTS+1];
  tok_t          last;
  wr_t           wr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          busy;
  logic          go;
  logic          take;
  logic          adv;
  logic          full;
  logic [15:0]   hold_base;
  logic [15:0]   hold_limit;
  logic [63:0]   hold_name;
  logic [2:0]    res_status;
  logic [3:0]    res_num;
  logic [15:0]   res_base;
  logic [15:0]   res_limit;
  logic [63:0]   res_name;

  assign s_tready = !busy && !rst;
  assign go       = s_tvalid && s_tready && (s_tuser != ACT_NONE);
  assign last     = chain[MAX_SEGMENTS];
  assign take     = last.valid && (!m_tvalid || m_tready);
  assign adv      = !last.valid || take;
  assign full     = cnt == CW'(MAX_SEGMENTS);

  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = go;
    chain[0].action = s_tuser;
    chain[0].nb     = s_tdata[15:0];
    chain[0].ne     = {1'b0, s_tdata[15:0]} + {1'b0, s_tdata[31:16]};
    chain[0].num    = s_tdata[99:96];
  end

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    stoc_cell #(
      .IDX(g),
      .CW (CW)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .count  (cnt),
      .wr     (wr),
      .tok_in (chain[g]),
      .tok_out(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hold_base  <= s_tdata[15:0];
      hold_limit <= s_tdata[31:16];
      hold_name  <= s_tdata[95:32];
    end
  end

  always_comb begin
    res_status = ST_CLEARED;
    res_num    = '0;
    res_base   = '0;
    res_limit  = '0;
    res_name   = '0;
    wr.en      = 1'b0;
    wr.base    = hold_base;
    wr.limit   = hold_limit;
    wr.name    = hold_name;
    cnt_next   = cnt;
    case (last.action)
      ACT_CLEAR: begin
        cnt_next = '0;
      end
      ACT_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else if (last.hit) begin
          res_status = ST_OVERLAP;
        end else begin
          res_status = ST_INSERTED;
          res_num    = 4'(cnt);
          wr.en      = take;
          cnt_next   = cnt + 1'b1;
        end
      end
      ACT_LOOKUP: begin
        res_num = last.num;
        if (last.found) begin
          res_status = ST_FOUND;
          res_base   = last.fbase;
          res_limit  = last.flimit;
          res_name   = last.fname;
        end else begin
          res_status = ST_MISSING;
        end
      end
      default: begin
        res_status = ST_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (go) begin
        busy <= 1'b1;
      end else if (take) begin
        busy <= 1'b0;
      end
      if (take) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tuser <= res_status;
      m_tdata <= {4'd0, res_name, res_limit, res_base, res_num};
    end
  end

endmodule

FILE: hdl/stoc_checker.sv
// Port-level checker for the segment table overlap check block, with its bind.
`include "segment_table_overlap_check_top_assert.svh"

module stoc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [103:0] s_tdata,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [2:0]   m_tuser
);
  import stoc_pkg::*;

  `STOC_ASSERT_NOW(a_zero_unless_found, m_tvalid && (m_tuser != ST_FOUND), m_tdata[103:4] == '0, "payload not zero outside found")
  `STOC_ASSERT_NOW(a_number_zero, m_tvalid && (m_tuser == ST_CLEARED || m_tuser == ST_OVERLAP || m_tuser == ST_FULL), m_tdata[3:0] == 4'd0, "segment number not zero")
  `STOC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `STOC_ASSERT_NEXT(a_drop_none, s_tvalid && s_tready && (s_tuser == ACT_NONE) && !m_tvalid, !m_tvalid, "result for unused action")

endmodule

bind segment_table_overlap_check_top stoc_checker u_stoc_checker (.*);

FILE: verif/segment_table_checker.sv
// Checker for the segment table: predicts each response and compares it with the result beats.
`timescale 1ns / 100ps

module segment_table_checker #(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic [2:0]   m_tuser,
  output int           fail_count,
  output int           pending_count,
  output int           checked_count,
  output logic [7:0]   statuses_seen
);
  import stoc_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  number;
    logic [15:0] base;
    logic [15:0] limit;
    logic [63:0] name;
  } seg_response_t;

  logic [15:0]   seg_base_tab  [MAX_SEGMENTS];
  logic [15:0]   seg_limit_tab [MAX_SEGMENTS];
  logic [63:0]   seg_name_tab  [MAX_SEGMENTS];
  int            seg_count;
  seg_response_t pending_responses[$];
  seg_response_t got;
  seg_response_t want;
  int            mismatches;
  int            observed;
  logic [7:0]    seen;

  initial begin
    for (int j = 0; j < MAX_SEGMENTS; j++) begin
      seg_base_tab[j]  = '0;
      seg_limit_tab[j] = '0;
      seg_name_tab[j]  = '0;
    end
    seg_count     = 0;
    mismatches    = 0;
    observed      = 0;
    seen          = '0;
  end

  task automatic predict_table_response(input logic [1:0] act, input logic [15:0] nb,
                                        input logic [15:0] nl, input logic [63:0] nm,
                                        input logic [3:0] num);
    seg_response_t r;
    logic [16:0]   new_end;
    logic [16:0]   old_end;
    logic          clash;
    r = '0;
    case (act)
      ACT_CLEAR: begin
        seg_count = 0;
        r.status = ST_CLEARED;
        pending_responses.push_back(r);
      end
      ACT_INSERT: begin
        if (seg_count >= MAX_SEGMENTS) begin
          r.status = ST_FULL;
        end else begin
          new_end = {1'b0, nb} + {1'b0, nl};
          clash = 1'b0;
          for (int j = 0; j < seg_count; j++) begin
            old_end = {1'b0, seg_base_tab[j]} + {1'b0, seg_limit_tab[j]};
            if (({1'b0, nb} < old_end) && ({1'b0, seg_base_tab[j]} < new_end))
              clash = 1'b1;
          end
          if (clash) begin
            r.status = ST_OVERLAP;
          end else begin
            seg_base_tab[seg_count]  = nb;
            seg_limit_tab[seg_count] = nl;
            seg_name_tab[seg_count]  = nm;
            r.status = ST_INSERTED;
            r.number = seg_count[3:0];
            seg_count++;
          end
        end
        pending_responses.push_back(r);
      end
      ACT_LOOKUP: begin
        r.number = num;
        if (int'(num) < seg_count) begin
          r.status = ST_FOUND;
          r.base   = seg_base_tab[num];
          r.limit  = seg_limit_tab[num];
          r.name   = seg_name_tab[num];
        end else begin
          r.status = ST_MISSING;
        end
        pending_responses.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.number = m_tdata[3:0];
        got.base   = m_tdata[19:4];
        got.limit  = m_tdata[35:20];
        got.name   = m_tdata[99:36];
        observed++;
        if (!$isunknown(got.status))
          seen[got.status] = 1'b1;
        if (pending_responses.size() == 0) begin
          $error("result beat with no response pending: status %0d", got.status);
          mismatches++;
        end else begin
          want = pending_responses.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.number !== want.number) begin
            $error("seg_number_out mismatch: expected %0d, got %0d", want.number, got.number);
            mismatches++;
          end
          if (got.base !== want.base) begin
            $error("seg_base_out mismatch: expected %h, got %h", want.base, got.base);
            mismatches++;
          end
          if (got.limit !== want.limit) begin
            $error("seg_limit_out mismatch: expected %h, got %h", want.limit, got.limit);
            mismatches++;
          end
          if (got.name !== want.name) begin
            $error("seg_name_out mismatch: expected %h, got %h", want.name, got.name);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_table_response(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[95:32],
                               s_tdata[99:96]);
    end
    fail_count    <= mismatches;
    pending_count <= pending_responses.size();
    checked_count <= observed;
    statuses_seen <= seen;
  end

endmodule

FILE: verif/testbench.sv
// Testbench top for the segment table: drives stimulus, idles both sides, reports the verdict.
`timescale 1ns / 100ps

module testbench;
  import stoc_pkg::*;

  localparam int TARGET_BEATS = 1550;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0]   s_tuser = ACT_NONE;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         no_idle = 1'b0;

  int           fail_count;
  int           pending_count;
  int           checked_count;
  logic [7:0]   statuses_seen;
  int           beats_sent = 0;
  int           act_hits [4] = '{0, 0, 0, 0};

  segment_table_overlap_check_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  segment_table_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .statuses_seen (statuses_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_beat(input logic [1:0] act, input logic [15:0] base,
                           input logic [15:0] lim, input logic [63:0] name,
                           input logic [3:0] num);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, num, name, lim, base};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    beats_sent++;
    act_hits[act]++;
  endtask

  function automatic logic [63:0] random_name();
    return {$urandom(), $urandom()};
  endfunction

  // result side: stall a random number of cycles before each result beat
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin
    int region;
    int off;
    int pick;
    int ops;
    int base;
    int lim;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: boundaries, zero-length spans, ignored action, missing entries
    send_beat(ACT_CLEAR, 16'hffff, 16'hffff, '1, 4'hf);
    send_beat(ACT_LOOKUP, '0, '0, '0, 4'd0);
    send_beat(ACT_INSERT, 16'h0000, 16'h0000, 64'h0, 4'd0);
    send_beat(ACT_INSERT, 16'h0000, 16'hffff, '1, 4'hf);
    send_beat(ACT_INSERT, 16'hffff, 16'hffff, 64'h0123_4567_89ab_cdef, 4'd0);
    send_beat(ACT_INSERT, 16'hfffe, 16'h0001, random_name(), 4'd0);
    send_beat(ACT_INSERT, 16'hffff, 16'h0000, random_name(), 4'd0);
    send_beat(ACT_NONE, 16'h1234, 16'h0010, random_name(), 4'd3);
    send_beat(ACT_LOOKUP, '0, '0, '0, 4'd1);
    send_beat(ACT_LOOKUP, '1, '1, '1, 4'd2);
    send_beat(ACT_LOOKUP, '0, '0, '0, 4'd5);
    repeat (11) send_beat(ACT_INSERT, 16'($urandom()), 16'h0000, random_name(), 4'd0);
    send_beat(ACT_INSERT, 16'h8000, 16'h0000, random_name(), 4'd0);
    send_beat(ACT_LOOKUP, '0, '0, '0, 4'd15);
    send_beat(ACT_CLEAR, '0, '0, '0, 4'd0);

    // random: mostly a clear followed by inserts in disjoint regions, with
    // collisions and lookups mixed in; the rest is unshaped noise
    while (beats_sent < TARGET_BEATS) begin
      no_idle <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        send_beat(ACT_CLEAR, 16'($urandom()), 16'($urandom()), random_name(),
                  4'($urandom()));
        region = 0;
        ops = $urandom_range(10, 32);
        repeat (ops) begin
          pick = $urandom_range(0, 99);
          if (pick < 65) begin
            if (region < 16) begin
              off  = $urandom_range(0, 4095);
              base = region * 4096 + off;
              lim  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 4096 - off);
              region++;
            end else begin
              base = $urandom_range(0, 65535);
              lim  = $urandom_range(0, 255);
            end
            send_beat(ACT_INSERT, 16'(base), 16'(lim), random_name(), 4'($urandom()));
          end else if (pick < 80) begin
            base = $urandom_range(0, (region == 0) ? 0 : region - 1) * 4096
                   + $urandom_range(0, 4095);
            lim  = $urandom_range(1, 8192);
            send_beat(ACT_INSERT, 16'(base), 16'(lim), random_name(), 4'($urandom()));
          end else if (pick < 96) begin
            send_beat(ACT_LOOKUP, 16'($urandom()), 16'($urandom()), random_name(),
                      4'($urandom_range(0, 15)));
          end else begin
            send_beat(ACT_NONE, 16'($urandom()), 16'($urandom()), random_name(),
                      4'($urandom()));
          end
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_beat(2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
                    random_name(), 4'($urandom()));
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("summary: %0d beats in (%0d clear, %0d insert, %0d lookup, %0d ignored)",
             beats_sent, act_hits[ACT_CLEAR], act_hits[ACT_INSERT], act_hits[ACT_LOOKUP],
             act_hits[ACT_NONE]);
    $display("summary: %0d responses checked, status codes seen %b, %0d mismatches",
             checked_count, statuses_seen[5:0], fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
